@@ hw/rtl/xce_pkg.sv @@
// Shared types, character codes and helpers for the XML character escape encoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package xce_pkg;

    // Character codes
    localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_X     = 8'h78;  // 'x'
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_APOS  = 8'h27;  // apostrophe
    localparam logic [7:0] CH_QUOT  = 8'h22;  // quote
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
    localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [7:0] CTRL_MAX = 8'd31;

    // Output sequence lengths
    localparam int ESC_LEN    = 6;  // "&#xHH;"
    localparam int PREFIX_LEN = 3;  // "&#x"
    localparam int IDX_W      = $clog2(ESC_LEN);

    localparam logic [IDX_W-1:0] IDX_AMP    = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_HASH   = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_X      = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_HI     = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_LO     = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_SEMI   = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_ESC_LAST    = IDX_W'(ESC_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_PREFIX_LAST = IDX_W'(PREFIX_LEN - 1);

    // Command queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        SCAN_NORMAL = 2'd0,
        SCAN_AMP    = 2'd1,
        SCAN_HASH   = 2'd2,
        SCAN_COPY   = 2'd3
    } scan_mode_t;

    typedef enum logic [1:0] {
        CUR_NONE  = 2'd0,
        CUR_PLAIN = 2'd1,
        CUR_ESC   = 2'd2
    } cur_kind_t;

    // Segment bit positions in a command's work mask, in output order
    localparam int SEG_AMP    = 0;
    localparam int SEG_HASH   = 1;
    localparam int SEG_PREFIX = 2;
    localparam int SEG_CUR    = 3;
    localparam int SEG_NUM    = 4;

    typedef struct packed {
        logic       esc_amp;   // held '&' flushed escaped
        logic       esc_hash;  // held '#' flushed escaped
        logic       prefix;    // "&#x" passed through
        cur_kind_t  cur_kind;  // how the current character goes out
        logic [7:0] ch;        // current character
        logic       str_end;   // item closes the string
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
        logic [7:0] base;
        base = lower ? CH_LA : CH_UA;
        if (v < 4'd10)
            return CH_ZERO + {4'd0, v};
        else
            return base + {4'd0, v} - 8'd10;
    endfunction

    function automatic logic is_reserved(input logic [7:0] c);
        return ((c != 8'd0) && (c <= CTRL_MAX)) || (c == CH_LT) || (c == CH_GT) ||
               (c == CH_AMP) || (c == CH_HASH) || (c == CH_APOS) || (c == CH_QUOT);
    endfunction

endpackage

@@ hw/rtl/xce_front.sv @@
// Front part: accepts input characters, tracks the reference prefix scan and
// emits one command per output-producing character. Depends on xce_pkg.
`timescale 1ns / 1ps

module xce_front
    import xce_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  logic [7:0]   item_char,
    input  logic         item_end,
    input  fifo_status_t queue_status,
    output logic         cmd_push,
    output cmd_t         cmd,
    output scan_mode_t   scan_mode
);

    scan_mode_t mode_reg;
    scan_mode_t mode_next;
    logic       accept;
    logic       plain_hold;
    cur_kind_t  plain_kind;

    assign item_ready = !queue_status.full;
    assign accept     = item_valid && item_ready;
    assign scan_mode  = mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= SCAN_NORMAL;
        else if (accept)
            mode_reg <= mode_next;
    end

    always_comb
    begin
        // normal-mode treatment of the current character
        plain_hold = (item_char == CH_AMP) && !item_end;
        if (plain_hold)
            plain_kind = CUR_NONE;
        else if (is_reserved(item_char))
            plain_kind = CUR_ESC;
        else
            plain_kind = CUR_PLAIN;

        mode_next    = mode_reg;
        cmd.esc_amp  = 1'b0;
        cmd.esc_hash = 1'b0;
        cmd.prefix   = 1'b0;
        cmd.cur_kind = CUR_NONE;
        cmd.ch       = item_char;
        cmd.str_end  = item_end;

        unique case (mode_reg)
            SCAN_NORMAL:
            begin
                cmd.cur_kind = plain_kind;
                mode_next    = plain_hold ? SCAN_AMP : SCAN_NORMAL;
            end
            SCAN_AMP:
            begin
                if ((item_char == CH_HASH) && !item_end)
                begin
                    mode_next = SCAN_HASH;
                end
                else
                begin
                    cmd.esc_amp  = 1'b1;
                    cmd.cur_kind = plain_kind;
                    mode_next    = plain_hold ? SCAN_AMP : SCAN_NORMAL;
                end
            end
            SCAN_HASH:
            begin
                if (item_char == CH_X)
                begin
                    cmd.prefix = 1'b1;
                    mode_next  = item_end ? SCAN_NORMAL : SCAN_COPY;
                end
                else
                begin
                    cmd.esc_amp  = 1'b1;
                    cmd.esc_hash = 1'b1;
                    cmd.cur_kind = plain_kind;
                    mode_next    = plain_hold ? SCAN_AMP : SCAN_NORMAL;
                end
            end
            SCAN_COPY:
            begin
                cmd.cur_kind = CUR_PLAIN;
                mode_next    = ((item_char == CH_SEMI) || item_end) ? SCAN_NORMAL : SCAN_COPY;
            end
            default:
            begin
                mode_next = SCAN_NORMAL;
            end
        endcase

        // hold-only characters produce no command
        cmd_push = accept && (cmd.esc_amp || cmd.esc_hash || cmd.prefix ||
                              (cmd.cur_kind != CUR_NONE));
    end

endmodule

@@ hw/rtl/xce_cmd_fifo.sv @@
// Short command queue between front and back parts; push and pop may share
// a cycle. Depends on xce_pkg.
`timescale 1ns / 1ps

module xce_cmd_fifo
    import xce_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  cmd_t         push_cmd,
    input  logic         pop,
    output cmd_t         head_cmd,
    output fifo_status_t status
);

    cmd_t                 mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/xce_back.sv @@
// Back part: expands the head command byte by byte into a registered output
// stage. Depends on xce_pkg.
`timescale 1ns / 1ps

module xce_back
    import xce_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         hex_lower,
    input  cmd_t         head_cmd,
    input  fifo_status_t queue_status,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   out_char,
    output logic         out_run_last,
    output logic         out_string_end
);

    logic [SEG_NUM-1:0] done_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               out_valid_reg;
    logic [7:0]         out_char_reg;
    logic               out_run_last_reg;
    logic               out_string_end_reg;

    logic [SEG_NUM-1:0] active;
    logic [SEG_NUM-1:0] remain;
    logic [SEG_NUM-1:0] seg_bit;
    logic [SEG_NUM-1:0] remain_after;
    logic               esc_seg;
    logic [7:0]         esc_code;
    logic [7:0]         byte_val;
    logic               seg_last;
    logic               cmd_last;
    logic               advance;
    logic               load;

    assign out_valid      = out_valid_reg;
    assign out_char       = out_char_reg;
    assign out_run_last   = out_run_last_reg;
    assign out_string_end = out_string_end_reg;

    assign advance = !out_valid_reg || out_ready;
    assign load    = advance && !queue_status.empty;

    always_comb
    begin
        active[SEG_AMP]    = head_cmd.esc_amp;
        active[SEG_HASH]   = head_cmd.esc_hash;
        active[SEG_PREFIX] = head_cmd.prefix;
        active[SEG_CUR]    = (head_cmd.cur_kind != CUR_NONE);
        remain             = active & ~done_reg;

        // lowest pending segment goes out first
        seg_bit  = remain & (~remain + 1'b1);
        esc_seg  = 1'b0;
        esc_code = head_cmd.ch;
        seg_last = 1'b0;
        byte_val = head_cmd.ch;

        unique case (seg_bit)
            SEG_NUM'(1 << SEG_AMP):
            begin
                esc_seg  = 1'b1;
                esc_code = CH_AMP;
            end
            SEG_NUM'(1 << SEG_HASH):
            begin
                esc_seg  = 1'b1;
                esc_code = CH_HASH;
            end
            SEG_NUM'(1 << SEG_PREFIX):
            begin
                esc_seg  = 1'b0;
            end
            SEG_NUM'(1 << SEG_CUR):
            begin
                esc_seg  = (head_cmd.cur_kind == CUR_ESC);
            end
            default:
            begin
                esc_seg  = 1'b0;
            end
        endcase

        if (seg_bit == SEG_NUM'(1 << SEG_CUR) && !esc_seg)
        begin
            // plain character: single byte
            byte_val = head_cmd.ch;
            seg_last = 1'b1;
        end
        else
        begin
            unique case (idx_reg)
                IDX_AMP:  byte_val = CH_AMP;
                IDX_HASH: byte_val = CH_HASH;
                IDX_X:    byte_val = CH_X;
                IDX_HI:   byte_val = hex_char(esc_code[7:4], hex_lower);
                IDX_LO:   byte_val = hex_char(esc_code[3:0], hex_lower);
                IDX_SEMI: byte_val = CH_SEMI;
                default:  byte_val = CH_SEMI;
            endcase
            seg_last = esc_seg ? (idx_reg == IDX_ESC_LAST) : (idx_reg == IDX_PREFIX_LAST);
        end

        remain_after = remain & ~seg_bit;
        cmd_last     = seg_last && (remain_after == '0);
        pop          = load && cmd_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
            idx_reg       <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= !queue_status.empty;
            if (load)
            begin
                if (cmd_last)
                begin
                    done_reg <= '0;
                    idx_reg  <= '0;
                end
                else if (seg_last)
                begin
                    done_reg <= done_reg | seg_bit;
                    idx_reg  <= '0;
                end
                else
                begin
                    idx_reg  <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg       <= byte_val;
            out_run_last_reg   <= cmd_last;
            out_string_end_reg <= cmd_last && head_cmd.str_end;
        end
    end

endmodule

@@ hw/rtl/xml_char_escape_encoder_unit.sv @@
// XML character escape encoder, top level: config register, front classifier,
// command queue and back expander. Depends on xce_pkg, xce_front, xce_cmd_fifo, xce_back.
`timescale 1ns / 1ps

// Streams one string character per transaction and writes its XML-safe form.
// Reserved characters ('<', '>', '&', '#', apostrophe, quote, codes 1 to 31)
// become "&#xHH;"; a run that already reads "&#x" passes through unchanged up
// to and including ';' or the end of the string. A leading '&' and then '#'
// are held back until the next character decides; on a mismatch or at the end
// of the string they flush escaped. An input transaction is accepted as long as
// the command queue (4 entries) has room; the back expander emits one byte per
// cycle while the output is ready, so a plain character costs one output byte,
// an escaped one six, and a flush up to eighteen, and output back pressure fills
// the queue and then stalls the input. The first output byte passes through the
// command queue and the registered output stage. tuser carries run_last (last
// byte caused by one input character), tlast carries string_end. Write
// hex_letters_lower through the cfg channel only while the block is idle.
module xml_char_escape_encoder_unit
    import xce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,        // [0] hex_letters_lower
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] in_char
    input  logic       s_axis_tlast,    // in_end
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_char
    output logic       m_axis_tuser,    // [0] run_last
    output logic       m_axis_tlast     // string_end
);

    logic         hex_lower_reg;
    logic         fifo_push;
    logic         fifo_pop;
    cmd_t         push_cmd;
    cmd_t         head_cmd;
    fifo_status_t fifo_status;
    scan_mode_t   front_mode;

    // Always take config writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hex_lower_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            hex_lower_reg <= cfg_data;
    end

    // Classify each character and track the prefix scan
    xce_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (s_axis_tvalid),
        .item_ready   (s_axis_tready),
        .item_char    (s_axis_tdata),
        .item_end     (s_axis_tlast),
        .queue_status (fifo_status),
        .cmd_push     (fifo_push),
        .cmd          (push_cmd),
        .scan_mode    (front_mode)
    );

    // Decouple classification from expansion
    xce_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_cmd (push_cmd),
        .pop      (fifo_pop),
        .head_cmd (head_cmd),
        .status   (fifo_status)
    );

    // Expand commands into output bytes
    xce_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .hex_lower      (hex_lower_reg),
        .head_cmd       (head_cmd),
        .queue_status   (fifo_status),
        .pop            (fifo_pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_char       (m_axis_tdata),
        .out_run_last   (m_axis_tuser),
        .out_string_end (m_axis_tlast)
    );

`ifndef ASSERT_OFF
    // The final byte of a string always closes a run
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("string_end without run_last");

    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_push && fifo_status.full))
        else $error("command queue overflow");

    // The scan returns to normal after the last character of a string
    a_end_resets_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (front_mode == SCAN_NORMAL))
        else $error("scan state not cleared at string end");

    // Nothing is popped from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_pop && fifo_status.empty))
        else $error("command queue underflow");
`endif

endmodule
